### sv/swm_pkg.sv
// Package for the sliding window maximum block.
// Holds the configuration register map and its fixed widths; no dependencies.
`default_nettype none

package swm_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned WS_W       = 7;

  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [WS_W-1:0]       WS_RESET        = 7'd4;

endpackage

`default_nettype wire

### sv/sliding_window_maximum_top.sv
// Sliding window maximum: monotonic candidate deque held in one synchronous memory.
// Depends on swm_pkg for the register map.
//
// Input channel (in_valid_i / in_stall_o) carries one sample item with a
// sequence_start flag that clears the window before that sample. Output
// channel (out_valid_o / out_stall_i) carries window_max once window_size
// samples of the current sequence have arrived. window_size is written over
// the APB port at byte address 0, by the user only while idle (the block does
// not enforce this); 0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW.
// An item is taken only in the idle state. It then passes through tail
// reads and compares that drop candidates not greater than it, head reads
// and compares that evict candidates that have left the window, and the
// append state, with in_stall_o high throughout; each sample is dropped or
// evicted once at most. The result is
// registered at the end of the append cycle and shows when in_stall_o drops.
// Reset clears the counters and pointers; the memory is not cleared. A
// stalled result stays in the output register while the next item is
// processed; a second result then holds in_stall_o high until it leaves.
`default_nettype none

module sliding_window_maximum_top
  import swm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW   = 64,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_value_i,
  input  wire logic                           sequence_start_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]      window_max_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [CFG_ADDR_W-1:0]          paddr,
  input  wire logic [CFG_DATA_W-1:0]          pwdata,
  output logic [CFG_DATA_W-1:0]               prdata,
  output logic                                pready
);

  localparam int unsigned AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PW   = $clog2(2 * MAX_WINDOW);
  localparam int unsigned WW   = (CW > WS_W) ? CW : WS_W;
  localparam int unsigned CMPW = (PW > WW) ? PW : WW;
  localparam int unsigned EW   = SAMPLE_WIDTH + PW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAIL_RD,
    ST_TAIL_CMP,
    ST_HEAD_RD,
    ST_HEAD_CMP,
    ST_APPEND,
    ST_WAIT
  } state_e;

  state_e                         state_q;
  logic [WS_W-1:0]                ws_q;
  logic [AW-1:0]                  head_q, tail_q;
  logic [CW-1:0]                  count_q;
  logic [PW-1:0]                  pos_q;
  logic [CW-1:0]                  fill_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic signed [SAMPLE_WIDTH-1:0] head_val_q;
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_data_q;

  logic [EW-1:0] mem [MAX_WINDOW];
  logic [EW-1:0] rdata_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic [AW-1:0]                  tail_prev, head_next, tail_next;
  logic [WW-1:0]                  ws_ext, win;
  logic signed [SAMPLE_WIDTH-1:0] cand_val;
  logic [PW-1:0]                  cand_pos;
  logic [PW:0]                    diff;
  logic [PW-1:0]                  age;
  logic                           evict;
  logic [CW-1:0]                  fill_next;
  logic                           emit;
  logic                           out_free;
  logic                           load_out;
  logic [PW-1:0]                  pos_next;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_WINDOW_SIZE) ? CFG_DATA_W'(ws_q) : '0;

  // Pointer arithmetic with wrap at MAX_WINDOW
  assign tail_prev = (tail_q == '0) ? AW'(MAX_WINDOW - 1) : tail_q - AW'(1);
  assign tail_next = (tail_q == AW'(MAX_WINDOW - 1)) ? '0 : tail_q + AW'(1);
  assign head_next = (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);
  assign pos_next  = (pos_q == PW'(2 * MAX_WINDOW - 1)) ? '0 : pos_q + PW'(1);

  assign ws_ext = WW'(ws_q);
  assign win    = (ws_q == '0) ? WW'(1) :
                  (ws_ext > WW'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : ws_ext;

  assign cand_val = rdata_q[SAMPLE_WIDTH-1:0];
  assign cand_pos = rdata_q[EW-1:SAMPLE_WIDTH];

  // Age modulo twice the window depth
  always_comb begin
    diff = {1'b0, pos_q} - {1'b0, cand_pos};
    if (diff[PW]) begin
      diff = diff + (PW+1)'(2 * MAX_WINDOW);
    end
    age = diff[PW-1:0];
  end

  assign evict     = CMPW'(age) >= CMPW'(win);
  assign fill_next = (fill_q == CW'(MAX_WINDOW)) ? fill_q : fill_q + CW'(1);
  assign emit      = WW'(fill_next) >= win;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign load_out  = (((state_q == ST_APPEND) && emit) || (state_q == ST_WAIT)) && out_free;

  assign rd_addr = (state_q == ST_TAIL_RD) ? tail_prev : head_q;
  assign wr_en   = (state_q == ST_APPEND);

  // Candidate memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= {pos_q, sample_q};
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ws_q        <= WS_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      sample_q    <= '0;
      head_val_q  <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr == REG_WINDOW_SIZE)) begin
        ws_q <= pwdata[WS_W-1:0];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        out_data_q  <= head_val_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            sample_q <= sample_value_i;
            if (sequence_start_i) begin
              head_q  <= '0;
              tail_q  <= '0;
              count_q <= '0;
              pos_q   <= '0;
              fill_q  <= '0;
            end
            state_q <= ST_TAIL_RD;
          end
        end
        ST_TAIL_RD: begin
          state_q <= (count_q == '0) ? ST_HEAD_RD : ST_TAIL_CMP;
        end
        ST_TAIL_CMP: begin
          if (cand_val <= sample_q) begin
            tail_q  <= tail_prev;
            count_q <= count_q - CW'(1);
            state_q <= ST_TAIL_RD;
          end else begin
            state_q <= ST_HEAD_RD;
          end
        end
        ST_HEAD_RD: begin
          if (count_q == '0) begin
            head_val_q <= sample_q;
            state_q    <= ST_APPEND;
          end else begin
            state_q <= ST_HEAD_CMP;
          end
        end
        ST_HEAD_CMP: begin
          if (evict) begin
            head_q  <= head_next;
            count_q <= count_q - CW'(1);
            state_q <= ST_HEAD_RD;
          end else begin
            head_val_q <= cand_val;
            state_q    <= ST_APPEND;
          end
        end
        ST_APPEND: begin
          tail_q  <= tail_next;
          count_q <= count_q + CW'(1);
          pos_q   <= pos_next;
          fill_q  <= fill_next;
          if (emit && !out_free) begin
            state_q <= ST_WAIT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_WAIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign window_max_o = out_data_q;

endmodule

`default_nettype wire

### sv/swm_checker.sv
// Port-level checker for sliding_window_maximum_top, attached by bind.
// Depends on swm_pkg for the register port widths.
`default_nettype none

module swm_checker
  import swm_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic [SAMPLE_WIDTH-1:0] window_max_o,
  input wire logic                    pready,
  input wire logic [CFG_ADDR_W-1:0]   paddr
);

  // One item in flight: an accepted item holds in_stall_o high in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on back-to-back cycles");

  // A new result only follows item processing
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item being processed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_max_o))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready || (paddr != REG_WINDOW_SIZE))
    else $error("register port not ready");

endmodule

bind sliding_window_maximum_top swm_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_swm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .window_max_o(window_max_o),
  .pready      (pready),
  .paddr       (paddr)
);

`default_nettype wire
